// ----- src/single_float_adder_truncating_defines.svh -----
// Assertion macros used by the adder pipeline file sfa_pipe.sv.
`ifndef SINGLE_FLOAT_ADDER_TRUNCATING_DEFINES_SVH
`define SINGLE_FLOAT_ADDER_TRUNCATING_DEFINES_SVH

// Implication checked on every edge outside reset.
`define SFA_ASSERT_IMPL(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define SFA_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("assertion failed");

`endif

// ----- src/sfa_pkg.sv -----
`default_nettype none
package sfa_pkg;
    localparam int unsigned FracW = 23;
    localparam int unsigned ExpW  = 8;
    localparam int unsigned MantW = 24;
    localparam int unsigned Stages = 4;
    localparam logic [FracW-1:0] FracMask = 23'h7FFFFF;
    localparam logic [MantW-1:0] HiddenBit = 24'h800000;

    typedef logic [31:0] t_word;

    // Count leading zeros of a 25-bit magnitude.
    function automatic logic [4:0] clz25(input logic [24:0] v);
        logic [4:0] n;
        logic       found;
        n = 5'd25;
        found = 1'b0;
        for (int i = 24; i >= 0; i--) begin
            if (!found && v[i]) begin
                n = 5'(24 - i);
                found = 1'b1;
            end
        end
        return n;
    endfunction
endpackage
`default_nettype wire

// ----- src/sfa_pipe.sv -----
`default_nettype none
`include "single_float_adder_truncating_defines.svh"
// Four-stage datapath: swap/align, add, leading-zero count, normalize.
module sfa_pipe (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_adv,
    input  wire              i_valid,
    input  sfa_pkg::t_word   i_a,
    input  sfa_pkg::t_word   i_b,
    output logic             o_valid,
    output sfa_pkg::t_word   o_sum
);
    import sfa_pkg::*;

    logic [Stages-1:0] r_v;

    // stage 1
    logic [ExpW-1:0]  r1_e;
    logic [MantW-1:0] r1_ml, r1_mt;
    logic             r1_sl, r1_st;
    // stage 2
    logic [ExpW-1:0]  r2_e;
    logic [24:0]      r2_mag;
    logic             r2_neg;
    // stage 3
    logic [ExpW-1:0]  r3_e;
    logic [24:0]      r3_mag;
    logic             r3_neg;
    logic [4:0]       r3_lz;
    // stage 4
    t_word            r4_sum;

    logic [ExpW-1:0]  n1_e, et;
    logic [ExpW-1:0]  align_sh;
    t_word            lead, trail;
    logic [MantW-1:0] mt;
    logic signed [25:0] n2_tot, sl, st;
    logic [24:0]      n2_mag;
    logic [24:0]      shl;
    logic [ExpW-1:0]  n4_e;
    logic [22:0]      n4_f;

    always_comb begin
        if (i_a[30:23] < i_b[30:23]) begin
            lead = i_b;
            trail = i_a;
        end else begin
            lead = i_a;
            trail = i_b;
        end
        n1_e = lead[30:23];
        et = trail[30:23];
        align_sh = n1_e - et;
        mt = HiddenBit | MantW'(trail[FracW-1:0] & FracMask);
        mt = (align_sh >= 8'd24) ? '0 : (mt >> align_sh[4:0]);
    end

    always_comb begin
        sl = r1_sl ? -$signed({2'b00, r1_ml}) : $signed({2'b00, r1_ml});
        st = r1_st ? -$signed({2'b00, r1_mt}) : $signed({2'b00, r1_mt});
        n2_tot = sl + st;
        n2_mag = n2_tot[25] ? 25'(-n2_tot) : n2_tot[24:0];
    end

    always_comb begin
        shl = '0;
        n4_e = r3_e;
        n4_f = '0;
        if (r3_mag[24]) begin
            n4_e = r3_e + 8'd1;
            n4_f = r3_mag[23:1];
        end else begin
            shl = r3_mag << (r3_lz - 5'd1);
            n4_e = r3_e - 8'(r3_lz - 5'd1);
            n4_f = shl[22:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_adv) begin
            r_v <= {r_v[Stages-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r1_e  <= n1_e;
            r1_ml <= HiddenBit | MantW'(lead[FracW-1:0] & FracMask);
            r1_mt <= mt;
            r1_sl <= lead[31];
            r1_st <= trail[31];
            r2_e   <= r1_e;
            r2_mag <= n2_mag;
            r2_neg <= n2_tot[25];
            r3_e   <= r2_e;
            r3_mag <= r2_mag;
            r3_neg <= r2_neg;
            r3_lz  <= clz25(r2_mag);
            if (r3_mag == '0) begin
                r4_sum <= '0;
            end else begin
                r4_sum <= {r3_neg, n4_e, n4_f};
            end
        end
    end

    assign o_valid = r_v[Stages-1];
    assign o_sum   = r4_sum;

    `SFA_ASSERT_NEXT(a_hold, i_clk, i_rst_n, !i_adv, $stable(r_v))
    `SFA_ASSERT_NEXT(a_adv, i_clk, i_rst_n, i_adv && i_valid, r_v[0])
    `SFA_ASSERT_IMPL(a_lz, i_clk, i_rst_n, r_v[2] && r3_mag != '0, r3_lz <= 5'd24)
endmodule
`default_nettype wire

// ----- src/single_float_adder_truncating.sv -----
// Channel  | Dir | tdata fields (low bit up)          | Notes
// s_axis   | in  | operand_a[31:0], operand_b[63:32]  | two single-precision addends
// m_axis   | out | sum_bits[31:0]                     | truncated sum, zero gives +0
//
// One transfer per cycle is accepted while m_axis does not stall the pipe.
// The four register stages (align, add, count, normalize) advance together.
// A stall on m_axis freezes the whole pipe; s_axis_tready drops only when the
// last stage holds a result that is not taken.
// Reset (i_rst_n low, synchronous) clears the stage valid bits only.
`default_nettype none
module single_float_adder_truncating (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [63:0] s_axis_tdata,   // operand_a[31:0], operand_b[63:32]
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [31:0] m_axis_tdata    // sum_bits[31:0]
);
    import sfa_pkg::*;

    logic adv;

    // Advance whenever the output slot is empty or being drained.
    assign adv = m_axis_tready || !m_axis_tvalid;
    assign s_axis_tready = adv;

    sfa_pipe u_pipe (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (s_axis_tvalid),
        .i_a     (s_axis_tdata[31:0]),
        .i_b     (s_axis_tdata[63:32]),
        .o_valid (m_axis_tvalid),
        .o_sum   (m_axis_tdata)
    );
endmodule
`default_nettype wire
